>>> design/crg_pkg.sv
// Shared types, register codes and helpers for the camera ray generator.
// No dependencies; every other file of the block but the port checker imports this package.
package crg_pkg;

	localparam int COORD_BITS_DEF = 12;

	// configuration register indexes
	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_W = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_H = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LENS   = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_X  = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_Y  = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_Z  = 4'd7;

	localparam int MODE_AA  = 0;
	localparam int MODE_DOF = 1;

	localparam logic [63:0] LENS_RST  = 64'h0001_0000_0000_0000;
	localparam logic [63:0] ROW_X_RST = 64'h4000_0000_0000_0000;
	localparam logic [63:0] ROW_Y_RST = 64'h0000_4000_0000_0000;
	localparam logic [63:0] ROW_Z_RST = 64'h0000_0000_4000_0000;

	// pixel center, one half in Q0.16
	localparam logic [15:0] HALF_FRAC = 16'h8000;

	localparam int RAD_W      = 64;
	localparam int ROOT_W     = 32;
	localparam int QUO_W      = 31;
	localparam int SQRT_STEPS = 4;
	localparam int DIV_STEPS  = 4;

	typedef struct packed {
		logic [2:0]        neg;
		logic              zero;
		logic [2:0][31:0]  org;
	} tail_t;

	typedef struct packed {
		logic [2:0][30:0]  an;
		tail_t             tail;
	} sq_side_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sh0000_0000_7FFF_FFFF)
			r = 32'sh7FFF_FFFF;
		else if (v < -64'sh0000_0000_8000_0000)
			r = 32'sh8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

>>> design/camera_ray_generator.sv
// Camera ray generator. One pixel sample enters per cycle while in_stall is
// low, and one ray leaves per sample, in order, after passing through 2 front
// stages, 2 transform stages, 5 direction set-up stages, 8 square-root stages,
// 9 divider stages and the output register.
// All stages advance together; a two-entry output buffer (output register
// plus skid entry) lets the pipeline keep taking samples while a ray waits,
// and in_stall rises only once that skid entry holds a ray. Registers are
// written through the cfg port (cfg_ready is always high) and must only be
// written while no ray is in flight. Depends on crg_pkg and the crg_ modules.
module camera_ray_generator import crg_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [COORD_BITS-1:0]   pixel_x,
	input  logic [COORD_BITS-1:0]   pixel_y,
	input  logic [15:0]             jitter_x,
	input  logic [15:0]             jitter_y,
	input  logic [15:0]             lens_u,
	input  logic [15:0]             lens_v,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [31:0]      origin_x,
	output logic signed [31:0]      origin_y,
	output logic signed [31:0]      origin_z,
	output logic signed [31:0]      direction_x,
	output logic signed [31:0]      direction_y,
	output logic signed [31:0]      direction_z,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [63:0]             cfg_data
);
	localparam int SIDE_W = $bits(sq_side_t);

	logic [1:0]  mode_q;
	logic [30:0] pitch_q, half_w_q, half_h_q;
	logic [63:0] lens_q;
	logic [2:0][63:0] rows_q;

	logic adv;

	logic               fr_v;
	logic signed [31:0] cx, cy, cz, ax, ay;
	logic               xf_v;
	logic [2:0][31:0]   px, org;
	logic               nm_v;
	sq_side_t           nm_side, sq_side;
	logic [RAD_W-1:0]   nm_sum;
	logic               sq_v;
	logic [ROOT_W-1:0]  sq_root;
	logic [SIDE_W-1:0]  sq_side_bits;
	logic               dv_v;
	logic [2:0][QUO_W-1:0] dv_quo;
	tail_t              dv_tail;

	logic [2:0][31:0]   org_d, dir_d;
	logic               main_v_q, skid_v_q;
	logic [2:0][31:0]   main_org_q, main_dir_q, skid_org_q, skid_dir_q;
	logic               take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= '0;
			pitch_q   <= '0;
			half_w_q  <= '0;
			half_h_q  <= '0;
			lens_q    <= LENS_RST;
			rows_q[0] <= ROW_X_RST;
			rows_q[1] <= ROW_Y_RST;
			rows_q[2] <= ROW_Z_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MODE:   mode_q    <= cfg_data[1:0];
				REG_PITCH:  pitch_q   <= cfg_data[30:0];
				REG_HALF_W: half_w_q  <= cfg_data[30:0];
				REG_HALF_H: half_h_q  <= cfg_data[30:0];
				REG_LENS:   lens_q    <= cfg_data;
				REG_ROW_X:  rows_q[0] <= cfg_data;
				REG_ROW_Y:  rows_q[1] <= cfg_data;
				REG_ROW_Z:  rows_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// the whole pipeline holds only while the skid entry is occupied
	assign adv      = !skid_v_q;
	assign in_stall = skid_v_q;

	crg_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk, .arst_n, .en(adv), .in_v(in_valid),
		.pixel_x, .pixel_y, .jitter_x, .jitter_y, .lens_u, .lens_v,
		.mode(mode_q), .pitch(pitch_q), .half_w(half_w_q), .half_h(half_h_q),
		.lens(lens_q), .out_v(fr_v), .cx, .cy, .cz, .ax, .ay
	);

	crg_xform u_xform (
		.clk, .arst_n, .en(adv), .in_v(fr_v), .rows(rows_q),
		.cx, .cy, .cz, .ax, .ay, .out_v(xf_v), .px, .org
	);

	crg_norm u_norm (
		.clk, .arst_n, .en(adv), .in_v(xf_v), .px, .org,
		.out_v(nm_v), .side(nm_side), .sum(nm_sum)
	);

	crg_sqrt #(.SIDE_W(SIDE_W)) u_sqrt (
		.clk, .arst_n, .en(adv), .in_v(nm_v), .rad(nm_sum),
		.side_in(nm_side), .out_v(sq_v), .root(sq_root), .side_out(sq_side_bits)
	);

	assign sq_side = sq_side_t'(sq_side_bits);

	crg_div u_div (
		.clk, .arst_n, .en(adv), .in_v(sq_v), .an(sq_side.an), .root(sq_root),
		.tail_in(sq_side.tail), .out_v(dv_v), .quo(dv_quo), .tail_out(dv_tail)
	);

	always_comb begin
		logic signed [31:0] mag;
		for (int i = 0; i < 3; i++) begin
			mag = $signed({1'b0, dv_quo[i]});
			org_d[i] = dv_tail.org[i];
			if (dv_tail.zero)
				dir_d[i] = '0;
			else if (dv_tail.neg[i])
				dir_d[i] = -mag;
			else
				dir_d[i] = mag;
		end
	end

	assign take = main_v_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (take) begin
				main_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end
		end else if (!main_v_q || take) begin
			main_v_q <= dv_v;
		end else if (dv_v) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take) begin
				main_org_q <= skid_org_q;
				main_dir_q <= skid_dir_q;
			end
		end else if (!main_v_q || take) begin
			main_org_q <= org_d;
			main_dir_q <= dir_d;
		end else begin
			skid_org_q <= org_d;
			skid_dir_q <= dir_d;
		end
	end

	assign out_valid   = main_v_q;
	assign origin_x    = main_org_q[0];
	assign origin_y    = main_org_q[1];
	assign origin_z    = main_org_q[2];
	assign direction_x = main_dir_q[0];
	assign direction_y = main_dir_q[1];
	assign direction_z = main_dir_q[2];

endmodule

>>> design/crg_front.sv
// Front stages: pixel offset and aperture products, then canvas point and
// aperture point (zero outside depth-of-field mode) with saturation. Depends on crg_pkg.
module crg_front import crg_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_v,
	input  logic [COORD_BITS-1:0]  pixel_x,
	input  logic [COORD_BITS-1:0]  pixel_y,
	input  logic [15:0]            jitter_x,
	input  logic [15:0]            jitter_y,
	input  logic [15:0]            lens_u,
	input  logic [15:0]            lens_v,
	input  logic [1:0]             mode,
	input  logic [30:0]            pitch,
	input  logic [30:0]            half_w,
	input  logic [30:0]            half_h,
	input  logic [63:0]            lens,
	output logic                   out_v,
	output logic signed [31:0]     cx,
	output logic signed [31:0]     cy,
	output logic signed [31:0]     cz,
	output logic signed [31:0]     ax,
	output logic signed [31:0]     ay
);
	localparam int PQ_W   = COORD_BITS + 16;
	localparam int PROD_W = PQ_W + 31;

	logic [15:0]        fx, fy;
	logic               v_s1, v_s2;
	logic [PROD_W-1:0]  prod_x_s1, prod_y_s1;
	logic [47:0]        apu_s1, apv_s1;
	logic signed [31:0] cx_s2, cy_s2, cz_s2, ax_s2, ay_s2;

	assign fx = mode[MODE_AA] ? jitter_x : HALF_FRAC;
	assign fy = mode[MODE_AA] ? jitter_y : HALF_FRAC;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_x_s1 <= PROD_W'({pixel_x, fx}) * PROD_W'(pitch);
			prod_y_s1 <= PROD_W'({pixel_y, fy}) * PROD_W'(pitch);
			apu_s1    <= 48'(lens_u) * 48'(lens[31:0]);
			apv_s1    <= 48'(lens_v) * 48'(lens[31:0]);
			cx_s2 <= sat32($signed(64'(half_w)) - $signed(64'(prod_x_s1[PROD_W-1:16])));
			cy_s2 <= sat32($signed(64'(half_h)) - $signed(64'(prod_y_s1[PROD_W-1:16])));
			cz_s2 <= sat32(-$signed(64'(lens[63:32])));
			ax_s2 <= mode[MODE_DOF] ?
				sat32($signed(64'(apu_s1[47:16])) - $signed(64'(lens[31:1]))) : '0;
			ay_s2 <= mode[MODE_DOF] ?
				sat32($signed(64'(apv_s1[47:16])) - $signed(64'(lens[31:1]))) : '0;
		end
	end

	assign out_v = v_s2;
	assign cx = cx_s2;
	assign cy = cy_s2;
	assign cz = cz_s2;
	assign ax = ax_s2;
	assign ay = ay_s2;

endmodule

>>> design/crg_xform.sv
// Affine transform of canvas and aperture points by the three matrix rows:
// one stage of products, one stage of sums with floor and saturation.
// Depends on crg_pkg.
module crg_xform import crg_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_v,
	input  logic [2:0][63:0]       rows,
	input  logic signed [31:0]     cx,
	input  logic signed [31:0]     cy,
	input  logic signed [31:0]     cz,
	input  logic signed [31:0]     ax,
	input  logic signed [31:0]     ay,
	output logic                   out_v,
	output logic [2:0][31:0]       px,
	output logic [2:0][31:0]       org
);
	logic               v_s3, v_s4;
	logic signed [47:0] pc_s3 [3][3];
	logic signed [47:0] po_s3 [3][2];
	logic [2:0][31:0]   px_s4, org_s4;
	logic [2:0][31:0]   px_s4_d, org_s4_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s3 <= in_v;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				pc_s3[r][0] <= $signed(rows[r][63:48]) * cx;
				pc_s3[r][1] <= $signed(rows[r][47:32]) * cy;
				pc_s3[r][2] <= $signed(rows[r][31:16]) * cz;
				po_s3[r][0] <= $signed(rows[r][63:48]) * ax;
				po_s3[r][1] <= $signed(rows[r][47:32]) * ay;
			end
		end
	end

	// sum in Q.30, floor back to Q16.16
	always_comb begin
		logic signed [63:0] t, e0, e1, e2, o0, o1;
		for (int r = 0; r < 3; r++) begin
			t  = $signed(rows[r][15:0]);
			t  = t <<< 22;
			e0 = pc_s3[r][0];
			e1 = pc_s3[r][1];
			e2 = pc_s3[r][2];
			o0 = po_s3[r][0];
			o1 = po_s3[r][1];
			px_s4_d[r]  = sat32((e0 + e1 + e2 + t) >>> 14);
			org_s4_d[r] = sat32((o0 + o1 + t) >>> 14);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s4  <= px_s4_d;
			org_s4 <= org_s4_d;
		end
	end

	assign out_v = v_s4;
	assign px    = px_s4;
	assign org   = org_s4;

endmodule

>>> design/crg_norm.sv
// Direction set-up: difference and magnitude, leading-one search, normalizing
// shift, squares and their sum. Depends on crg_pkg.
module crg_norm import crg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_v,
	input  logic [2:0][31:0]   px,
	input  logic [2:0][31:0]   org,
	output logic               out_v,
	output sq_side_t           side,
	output logic [RAD_W-1:0]   sum
);
	logic              v_s5, v_s6, v_s7, v_s8, v_s9;
	logic [2:0][32:0]  a_s5, a_s6;
	logic [32:0]       m_s5;
	logic [2:0]        neg_s5, neg_s6, neg_s7, neg_s8, neg_s9;
	logic [2:0][31:0]  org_s5, org_s6, org_s7, org_s8, org_s9;
	logic              zero_s6, zero_s7, zero_s8, zero_s9;
	logic [4:0]        left_s6;
	logic [1:0]        right_s6;
	logic [2:0][30:0]  an_s7, an_s8, an_s9;
	logic [2:0][61:0]  sq_s8;
	logic [RAD_W-1:0]  sum_s9;

	logic [2:0][32:0]  a_d;
	logic [2:0]        neg_d;
	logic [32:0]       m_d;
	logic [5:0]        msb;
	logic [2:0][30:0]  an_d;

	always_comb begin
		logic signed [32:0] d;
		m_d = '0;
		for (int i = 0; i < 3; i++) begin
			d = $signed({px[i][31], px[i]}) - $signed({org[i][31], org[i]});
			neg_d[i] = d[32];
			a_d[i] = d[32] ? 33'(-d) : 33'(d);
		end
		for (int i = 0; i < 3; i++)
			if (a_d[i] > m_d)
				m_d = a_d[i];
	end

	always_comb begin
		msb = '0;
		for (int b = 0; b < 33; b++)
			if (m_s5[b])
				msb = 6'(b);
	end

	always_comb begin
		logic [63:0] w;
		for (int i = 0; i < 3; i++) begin
			w = 64'(a_s6[i]) << left_s6;
			w = w >> right_s6;
			an_d[i] = w[30:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s5 <= in_v;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s5    <= a_d;
			m_s5    <= m_d;
			neg_s5  <= neg_d;
			org_s5  <= org;
			// bring the largest magnitude into [2^30, 2^31)
			a_s6     <= a_s5;
			zero_s6  <= (m_s5 == '0);
			left_s6  <= (msb < 6'd30) ? 5'(6'd30 - msb) : '0;
			right_s6 <= (msb > 6'd30) ? 2'(msb - 6'd30) : '0;
			neg_s6   <= neg_s5;
			org_s6   <= org_s5;
			an_s7   <= an_d;
			zero_s7 <= zero_s6;
			neg_s7  <= neg_s6;
			org_s7  <= org_s6;
			for (int i = 0; i < 3; i++)
				sq_s8[i] <= 62'(an_s7[i]) * 62'(an_s7[i]);
			an_s8   <= an_s7;
			zero_s8 <= zero_s7;
			neg_s8  <= neg_s7;
			org_s8  <= org_s7;
			sum_s9  <= RAD_W'(sq_s8[0]) + RAD_W'(sq_s8[1]) + RAD_W'(sq_s8[2]);
			an_s9   <= an_s8;
			zero_s9 <= zero_s8;
			neg_s9  <= neg_s8;
			org_s9  <= org_s8;
		end
	end

	assign out_v          = v_s9;
	assign sum            = sum_s9;
	assign side.an        = an_s9;
	assign side.tail.neg  = neg_s9;
	assign side.tail.zero = zero_s9;
	assign side.tail.org  = org_s9;

endmodule

>>> design/crg_sqrt.sv
// Pipelined floor square root of a 64-bit value, STEPS root bits per stage,
// with a side payload that travels alongside. Depends on crg_pkg.
module crg_sqrt import crg_pkg::*; #(
	parameter int SIDE_W = 1,
	parameter int STEPS  = SQRT_STEPS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_v,
	input  logic [RAD_W-1:0]    rad,
	input  logic [SIDE_W-1:0]   side_in,
	output logic                out_v,
	output logic [ROOT_W-1:0]   root,
	output logic [SIDE_W-1:0]   side_out
);
	localparam int NST   = ROOT_W / STEPS;
	localparam int REM_W = ROOT_W + 4;

	logic              v_s    [NST];
	logic [RAD_W-1:0]  rad_s  [NST];
	logic [REM_W-1:0]  rem_s  [NST];
	logic [ROOT_W-1:0] root_s [NST];
	logic [SIDE_W-1:0] side_s [NST];

	for (genvar k = 0; k < NST; k++) begin : g_st
		logic              v_i;
		logic [RAD_W-1:0]  rad_i, rad_n;
		logic [REM_W-1:0]  rem_i, rem_n;
		logic [ROOT_W-1:0] root_i, root_n;
		logic [SIDE_W-1:0] side_i;

		if (k == 0) begin : g_in
			assign v_i    = in_v;
			assign rad_i  = rad;
			assign rem_i  = '0;
			assign root_i = '0;
			assign side_i = side_in;
		end else begin : g_mid
			assign v_i    = v_s[k-1];
			assign rad_i  = rad_s[k-1];
			assign rem_i  = rem_s[k-1];
			assign root_i = root_s[k-1];
			assign side_i = side_s[k-1];
		end

		always_comb begin
			logic [REM_W-1:0] trial;
			rad_n  = rad_i;
			rem_n  = rem_i;
			root_n = root_i;
			for (int j = 0; j < STEPS; j++) begin
				rem_n = {rem_n[REM_W-3:0], rad_n[RAD_W-1:RAD_W-2]};
				rad_n = rad_n << 2;
				trial = REM_W'({root_n, 2'b01});
				if (rem_n >= trial) begin
					rem_n  = rem_n - trial;
					root_n = {root_n[ROOT_W-2:0], 1'b1};
				end else begin
					root_n = {root_n[ROOT_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[k] <= 1'b0;
			else if (en)
				v_s[k] <= v_i;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k]  <= rad_n;
				rem_s[k]  <= rem_n;
				root_s[k] <= root_n;
				side_s[k] <= side_i;
			end
		end
	end

	assign out_v    = v_s[NST-1];
	assign root     = root_s[NST-1];
	assign side_out = side_s[NST-1];

endmodule

>>> design/crg_div.sv
// Three-lane pipelined restoring divider: (a * 2^30 + r/2) / r for each
// direction component, at most STEPS quotient bits per stage. Depends on crg_pkg.
module crg_div import crg_pkg::*; #(
	parameter int STEPS = DIV_STEPS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_v,
	input  logic [2:0][30:0]     an,
	input  logic [ROOT_W-1:0]    root,
	input  tail_t                tail_in,
	output logic                 out_v,
	output logic [2:0][QUO_W-1:0] quo,
	output tail_t                tail_out
);
	localparam int NST    = (QUO_W + STEPS - 1) / STEPS;
	localparam int DREM_W = ROOT_W + 1;

	logic                    v_s1;
	logic [2:0][DREM_W-1:0]  rem_s1;
	logic [2:0][QUO_W-1:0]   nb_s1;
	logic [ROOT_W-1:0]       d_s1;
	tail_t                   tail_s1;

	logic                    v_s    [NST];
	logic [2:0][DREM_W-1:0]  rem_s  [NST];
	logic [2:0][QUO_W-1:0]   nb_s   [NST];
	logic [2:0][QUO_W-1:0]   q_s    [NST];
	logic [ROOT_W-1:0]       d_s    [NST];
	tail_t                   tail_s [NST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= in_v;
	end

	// numerator with rounding term; its top bits already lie below the divisor
	always_ff @(posedge clk) begin
		logic [61:0] num;
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				num = 62'({an[i], 30'b0}) + 62'(root[ROOT_W-1:1]);
				rem_s1[i] <= DREM_W'(num[61:QUO_W]);
				nb_s1[i]  <= num[QUO_W-1:0];
			end
			d_s1    <= root;
			tail_s1 <= tail_in;
		end
	end

	for (genvar k = 0; k < NST; k++) begin : g_st
		logic                    v_i;
		logic [2:0][DREM_W-1:0]  rem_i, rem_n;
		logic [2:0][QUO_W-1:0]   nb_i, nb_n, q_i, q_n;
		logic [ROOT_W-1:0]       d_i;
		tail_t                   tail_i;

		if (k == 0) begin : g_in
			assign v_i    = v_s1;
			assign rem_i  = rem_s1;
			assign nb_i   = nb_s1;
			assign q_i    = '0;
			assign d_i    = d_s1;
			assign tail_i = tail_s1;
		end else begin : g_mid
			assign v_i    = v_s[k-1];
			assign rem_i  = rem_s[k-1];
			assign nb_i   = nb_s[k-1];
			assign q_i    = q_s[k-1];
			assign d_i    = d_s[k-1];
			assign tail_i = tail_s[k-1];
		end

		always_comb begin
			rem_n = rem_i;
			nb_n  = nb_i;
			q_n   = q_i;
			for (int l = 0; l < 3; l++) begin
				for (int j = 0; j < STEPS; j++) begin
					if (k * STEPS + j < QUO_W) begin
						rem_n[l] = {rem_n[l][DREM_W-2:0], nb_n[l][QUO_W-1]};
						nb_n[l]  = nb_n[l] << 1;
						if (rem_n[l] >= DREM_W'(d_i)) begin
							rem_n[l] = rem_n[l] - DREM_W'(d_i);
							q_n[l]   = {q_n[l][QUO_W-2:0], 1'b1};
						end else begin
							q_n[l]   = {q_n[l][QUO_W-2:0], 1'b0};
						end
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[k] <= 1'b0;
			else if (en)
				v_s[k] <= v_i;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= rem_n;
				nb_s[k]   <= nb_n;
				q_s[k]    <= q_n;
				d_s[k]    <= d_i;
				tail_s[k] <= tail_i;
			end
		end
	end

	assign out_v    = v_s[NST-1];
	assign quo      = q_s[NST-1];
	assign tail_out = tail_s[NST-1];

endmodule

>>> design/crg_checker.sv
// Port-level checks for the camera ray generator, bound to the top level.
// Depends only on the top level's ports.
module crg_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] origin_x,
	input logic signed [31:0] direction_x,
	input logic signed [31:0] direction_y,
	input logic signed [31:0] direction_z
);
	localparam logic signed [31:0] UNIT      = 32'sh4000_0000;
	localparam logic signed [31:0] HALF_UNIT = 32'sh2000_0000;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("ray dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(origin_x) && $stable(direction_x)
			&& $stable(direction_y) && $stable(direction_z))
		else $error("ray changed while stalled");

	// a unit vector never has a component beyond one
	a_dir_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> direction_x <= UNIT && direction_x >= -UNIT
			&& direction_y <= UNIT && direction_y >= -UNIT
			&& direction_z <= UNIT && direction_z >= -UNIT)
		else $error("direction component out of range");

	// a nonzero unit vector has its largest component above one over root three, so at least one half
	a_dir_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (direction_x != 0 || direction_y != 0 || direction_z != 0)
		|-> direction_x >= HALF_UNIT || direction_x <= -HALF_UNIT
			|| direction_y >= HALF_UNIT || direction_y <= -HALF_UNIT
			|| direction_z >= HALF_UNIT || direction_z <= -HALF_UNIT)
		else $error("direction too short to be normalized");

endmodule

bind camera_ray_generator crg_checker u_crg_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.origin_x(origin_x),
	.direction_x(direction_x),
	.direction_y(direction_y),
	.direction_z(direction_z)
);

>>> tb/sv/crg_checker.sv
`timescale 1ns / 1ps
// Ray checker for camera_ray_generator: watches the sample, ray and register
// channels, predicts each ray and compares. Depends on crg_pkg.
module crg_ray_checker import crg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [11:0]           pixel_x,
	input  logic [11:0]           pixel_y,
	input  logic [15:0]           jitter_x,
	input  logic [15:0]           jitter_y,
	input  logic [15:0]           lens_u,
	input  logic [15:0]           lens_v,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic signed [31:0]    origin_x,
	input  logic signed [31:0]    origin_y,
	input  logic signed [31:0]    origin_z,
	input  logic signed [31:0]    direction_x,
	input  logic signed [31:0]    direction_y,
	input  logic signed [31:0]    direction_z,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [63:0]           cfg_data,
	output int                    fail_count,
	output int                    pending_rays,
	output int                    rays_seen
);

	typedef struct {
		logic signed [31:0] org[3];
		logic signed [31:0] dir[3];
	} ray_t;

	ray_t expected_rays[$];

	logic [1:0]  mode_q;
	logic [30:0] pitch_q, half_w_q, half_h_q;
	logic [63:0] lens_q, row_q[3];

	function automatic string org_name(int k);
		string s;
		case (k)
			0: s = "origin_x";
			1: s = "origin_y";
			default: s = "origin_z";
		endcase
		return s;
	endfunction

	function automatic string dir_name(int k);
		string s;
		case (k)
			0: s = "direction_x";
			1: s = "direction_y";
			default: s = "direction_z";
		endcase
		return s;
	endfunction

	function automatic longint floor14(longint v);
		return v >>> 14;
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint xform(logic [63:0] row, longint cx, longint cy, longint cz);
		longint acc;
		acc = longint'($signed(row[63:48])) * cx + longint'($signed(row[47:32])) * cy
			+ longint'($signed(row[31:16])) * cz + longint'($signed(row[15:0])) * 4194304;
		return clamp32(floor14(acc));
	endfunction

	function automatic longint offset_of(logic [11:0] p, logic [15:0] f);
		logic [63:0] pq;
		pq = {36'd0, p, f};
		return longint'((pq * {33'd0, pitch_q}) >> 16);
	endfunction

	function automatic logic [63:0] root_floor(logic [63:0] x);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x = x - (res + b);
				res = (res >> 1) + b;
			end else
				res = res >> 1;
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic ray_t trace_ray(logic [11:0] px_i, logic [11:0] py_i,
		logic [15:0] jx, logic [15:0] jy, logic [15:0] u, logic [15:0] v);
		ray_t r;
		longint cx, cy, cz, ax, ay, cp[3], dd[3];
		logic [63:0] mag[3], mx, sum, nrm, ap, q;
		ax = 0;
		ay = 0;
		cx = clamp32(longint'(half_w_q) - offset_of(px_i, mode_q[MODE_AA] ? jx : HALF_FRAC));
		cy = clamp32(longint'(half_h_q) - offset_of(py_i, mode_q[MODE_AA] ? jy : HALF_FRAC));
		cz = clamp32(-longint'({32'd0, lens_q[63:32]}));
		if (mode_q[MODE_DOF]) begin
			ap = {32'd0, lens_q[31:0]};
			ax = clamp32(longint'(({48'd0, u} * ap) >> 16) - longint'(ap >> 1));
			ay = clamp32(longint'(({48'd0, v} * ap) >> 16) - longint'(ap >> 1));
		end
		mx = 0;
		for (int i = 0; i < 3; i++) begin
			cp[i] = xform(row_q[i], cx, cy, cz);
			r.org[i] = 32'(xform(row_q[i], ax, ay, 0));
			dd[i] = cp[i] - longint'(r.org[i]);
			mag[i] = dd[i] < 0 ? -dd[i] : dd[i];
			if (mag[i] > mx) mx = mag[i];
			r.dir[i] = 0;
		end
		if (mx == 0) return r;
		while (mx < (64'd1 << 30)) begin
			mx = mx << 1;
			for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
		end
		while (mx >= (64'd1 << 31)) begin
			mx = mx >> 1;
			for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
		end
		sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
		nrm = root_floor(sum);
		for (int i = 0; i < 3; i++) begin
			q = ((mag[i] << 30) + (nrm >> 1)) / nrm;
			r.dir[i] = dd[i] < 0 ? -q[31:0] : q[31:0];
		end
		return r;
	endfunction

	assign pending_rays = expected_rays.size();

	always @(posedge clk or negedge arst_n) begin
		ray_t got, want;
		int errs;
		if (!arst_n) begin
			mode_q <= 0;
			pitch_q <= 0;
			half_w_q <= 0;
			half_h_q <= 0;
			lens_q <= LENS_RST;
			row_q[0] <= ROW_X_RST;
			row_q[1] <= ROW_Y_RST;
			row_q[2] <= ROW_Z_RST;
			fail_count <= 0;
			rays_seen <= 0;
			expected_rays.delete();
		end else begin
			errs = 0;
			if (out_valid && !out_stall) begin
				got.org[0] = origin_x; got.org[1] = origin_y; got.org[2] = origin_z;
				got.dir[0] = direction_x; got.dir[1] = direction_y; got.dir[2] = direction_z;
				rays_seen <= rays_seen + 1;
				if (expected_rays.size() == 0) begin
					$error("ray transfer with nothing expected");
					errs++;
				end else begin
					want = expected_rays.pop_front();
					for (int i = 0; i < 3; i++) begin
						if (got.org[i] !== want.org[i]) begin
							$error("%s expected %0d got %0d", org_name(i), want.org[i],
								got.org[i]);
							errs++;
						end
						if (got.dir[i] !== want.dir[i]) begin
							$error("%s expected %0d got %0d", dir_name(i), want.dir[i],
								got.dir[i]);
							errs++;
						end
					end
				end
			end
			if (errs != 0)
				fail_count <= fail_count + errs;
			if (in_valid && !in_stall)
				expected_rays.push_back(trace_ray(pixel_x, pixel_y, jitter_x, jitter_y,
					lens_u, lens_v));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MODE:   mode_q <= cfg_data[1:0];
					REG_PITCH:  pitch_q <= cfg_data[30:0];
					REG_HALF_W: half_w_q <= cfg_data[30:0];
					REG_HALF_H: half_h_q <= cfg_data[30:0];
					REG_LENS:   lens_q <= cfg_data;
					REG_ROW_X:  row_q[0] <= cfg_data;
					REG_ROW_Y:  row_q[1] <= cfg_data;
					REG_ROW_Z:  row_q[2] <= cfg_data;
					default: ;
				endcase
			end
		end
	end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// Top of the camera_ray_generator testbench: clock, reset, samples, register
// writes and verdict. Depends on crg_pkg, camera_ray_generator and crg_ray_checker.
module tb;
	import crg_pkg::*;

	// indexes past the register list; writes to them are dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 4'd9;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 4'd15;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
	logic [11:0] pixel_x, pixel_y;
	logic [15:0] jitter_x, jitter_y, lens_u, lens_v;
	logic signed [31:0] origin_x, origin_y, origin_z;
	logic signed [31:0] direction_x, direction_y, direction_z;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [63:0] cfg_data;
	int fail_count, pending_rays, rays_seen;
	bit hold_off;

	camera_ray_generator u_top (.*);
	crg_ray_checker u_chk (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Verification failed");
		$finish;
	end

	function automatic int gap_len();
		int k;
		k = $urandom_range(0, 99);
		if (k < 55) return 0;
		if (k < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// receiver: random stalls, plus one long hold-off when asked
	initial begin
		int n;
		out_stall = 0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_stall <= 1;
				repeat (80) @(posedge clk);
				hold_off = 0;
				out_stall <= 0;
			end else begin
				n = gap_len();
				out_stall <= n != 0;
				repeat (n) @(posedge clk);
				out_stall <= 0;
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
	endtask

	task automatic send_sample(logic [11:0] x, logic [11:0] y, logic [15:0] jx,
		logic [15:0] jy, logic [15:0] u, logic [15:0] v, bit gaps);
		int n;
		n = gaps ? gap_len() : 0;
		if (n != 0) begin
			in_valid <= 0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1;
		pixel_x <= x; pixel_y <= y; jitter_x <= jx; jitter_y <= jy;
		lens_u <= u; lens_v <= v;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (pending_rays != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [63:0] rand_row();
		logic [15:0] t[3];
		for (int i = 0; i < 3; i++)
			t[i] = $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 16'h8000) - 16'h4000);
		return {t[0], t[1], t[2], 16'($urandom_range(0, 16'h0800) - 16'h0400)};
	endfunction

	task automatic random_setup(int kind);
		write_reg(REG_MODE, 64'($urandom_range(0, 3)));
		if (kind == 0) begin
			write_reg(REG_PITCH, 64'($urandom_range(64, 2048)));
			write_reg(REG_HALF_W, 64'($urandom_range(0, 32'h0200_0000)));
			write_reg(REG_HALF_H, 64'($urandom_range(0, 32'h0200_0000)));
			write_reg(REG_LENS, {32'($urandom_range(0, 32'h0010_0000)),
				32'($urandom_range(0, 32'h0008_0000))});
			write_reg(REG_ROW_X, rand_row());
			write_reg(REG_ROW_Y, rand_row());
			write_reg(REG_ROW_Z, rand_row());
		end else begin
			write_reg(REG_PITCH, {$urandom, $urandom});
			write_reg(REG_HALF_W, {$urandom, $urandom});
			write_reg(REG_HALF_H, {$urandom, $urandom});
			write_reg(REG_LENS, {$urandom, $urandom});
			write_reg(REG_ROW_X, {$urandom, $urandom});
			write_reg(REG_ROW_Y, {$urandom, $urandom});
			write_reg(REG_ROW_Z, {$urandom, $urandom});
		end
		write_reg(REG_SPARE_LO, {$urandom, $urandom});
	endtask

	task automatic random_samples(int n);
		for (int i = 0; i < n; i++)
			send_sample(12'($urandom), 12'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom), 16'($urandom), i % 60 < 40);
	endtask

	initial begin
		in_valid = 0; cfg_valid = 0; cfg_index = 0; cfg_data = 0;
		pixel_x = 0; pixel_y = 0; jitter_x = 0; jitter_y = 0; lens_u = 0; lens_v = 0;
		hold_off = 0;
		arst_n = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset registers: zero pitch and canvas, identity view
		send_sample(0, 0, 0, 0, 0, 0, 0);
		send_sample(12'hFFF, 12'hFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
		drain();

		// zero-length direction: zero focal, zero canvas
		write_reg(REG_LENS, 64'd0);
		send_sample(0, 0, 0, 0, 0, 0, 0);
		drain();

		// extremes: both features on, largest sizes, saturating geometry
		write_reg(REG_MODE, 64'd3);
		write_reg(REG_PITCH, 64'h7FFF_FFFF);
		write_reg(REG_HALF_W, 64'hFFFF_FFFF);
		write_reg(REG_HALF_H, 64'h7FFF_FFFF);
		write_reg(REG_LENS, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_ROW_X, 64'h7FFF_8000_7FFF_7FFF);
		write_reg(REG_ROW_Y, 64'h8000_7FFF_8000_8000);
		write_reg(REG_ROW_Z, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_SPARE_HI, 64'd0);
		send_sample(0, 0, 0, 0, 0, 0, 0);
		send_sample(12'hFFF, 12'hFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
		send_sample(12'hAAA, 12'h555, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 0);
		send_sample(12'h555, 12'hAAA, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 0);
		drain();

		// each mode on a modest view
		for (int m = 0; m < 4; m++) begin
			random_setup(0);
			write_reg(REG_MODE, 64'(m));
			random_samples(4);
			drain();
		end

		// long hold-off on the ray side so the pipeline backs up
		random_setup(0);
		hold_off = 1;
		random_samples(60);
		drain();

		for (int p = 0; p < 12; p++) begin
			random_setup(p % 4 == 3);
			random_samples(55);
			drain();
		end

		$display("Ran %0d rays through all sampling modes, saturating and zero-length cases,",
			rays_seen);
		$display("random views and a long output hold-off.");
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
